// ----- hw/rtl/rrp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_pkg
// Types, codes and limits shared by the multi-bulk request parser modules.
// ----------------------------------------------------------------------------
package rrp_pkg;

   localparam int unsigned ACC_W      = 17;
   localparam int unsigned LINE_W     = 7;
   localparam int unsigned ARGS_BOUND = 128;
   localparam int unsigned LEN_BOUND  = 65534;

   localparam logic [ACC_W-1:0] ARGS_BOUND_V = ACC_W'(ARGS_BOUND);
   localparam logic [ACC_W-1:0] LEN_BOUND_V  = ACC_W'(LEN_BOUND);
   localparam logic [ACC_W-1:0] ACC_MAX      = {ACC_W{1'b1}};

   // stream characters
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_ZERO   = 8'h30;
   localparam logic [7:0] CH_NINE   = 8'h39;

   // event codes
   localparam logic [2:0] EV_HEADER  = 3'd0;
   localparam logic [2:0] EV_DATA    = 3'd1;
   localparam logic [2:0] EV_ARG_END = 3'd2;
   localparam logic [2:0] EV_CMD_END = 3'd3;
   localparam logic [2:0] EV_ERROR   = 3'd4;

   // error codes
   localparam logic [3:0] ERR_NONE     = 4'd0;
   localparam logic [3:0] ERR_LEAD     = 4'd1;
   localparam logic [3:0] ERR_DIGIT    = 4'd2;
   localparam logic [3:0] ERR_EMPTY    = 4'd3;
   localparam logic [3:0] ERR_COUNT    = 4'd4;
   localparam logic [3:0] ERR_LENGTH   = 4'd5;
   localparam logic [3:0] ERR_LONG     = 4'd6;
   localparam logic [3:0] ERR_FRAME    = 4'd7;
   localparam logic [3:0] ERR_CR_NO_LF = 4'd8;

   // register indexes
   localparam logic [1:0] CSR_MAX_ARGS    = 2'd0;
   localparam logic [1:0] CSR_MAX_ARG_LEN = 2'd1;
   localparam logic [1:0] CSR_COUNT_LIM   = 2'd2;
   localparam logic [1:0] CSR_LENGTH_LIM  = 2'd3;

   typedef enum logic [7:0] {
      PH_STAR    = 8'b0000_0001,
      PH_CNT     = 8'b0000_0010,
      PH_CNT_LF  = 8'b0000_0100,
      PH_DOLLAR  = 8'b0000_1000,
      PH_LEN     = 8'b0001_0000,
      PH_LEN_LF  = 8'b0010_0000,
      PH_DATA    = 8'b0100_0000,
      PH_DATA_LF = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0]        max_args;
      logic [15:0]       max_arg_len;
      logic [LINE_W-1:0] count_line_limit;
      logic [LINE_W-1:0] length_line_limit;
   } cfg_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  arg_byte;
      logic [6:0]  arg_index;
      logic [15:0] arg_length;
      logic [7:0]  arg_total;
      logic [3:0]  error_code;
   } result_type;

endpackage

// ----- hw/rtl/rrp_csr_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_csr_regs
// Configuration registers of the request parser, written through a plain
// write port.
// ----------------------------------------------------------------------------
module rrp_csr_regs
   import rrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output cfg_type     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_MAX_ARGS:    cfg_in.max_args          = csr_wdata[7:0];
            CSR_MAX_ARG_LEN: cfg_in.max_arg_len       = csr_wdata;
            CSR_COUNT_LIM:   cfg_in.count_line_limit  = csr_wdata[LINE_W-1:0];
            CSR_LENGTH_LIM:  cfg_in.length_line_limit = csr_wdata[LINE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_args          <= 8'd128;
         cfg_ff.max_arg_len       <= 16'd65534;
         cfg_ff.count_line_limit  <= LINE_W'(16);
         cfg_ff.length_line_limit <= LINE_W'(16);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- hw/rtl/rrp_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_parser
// Parse state and combinational next-state logic: one byte per step, result
// formed combinationally from the registered byte.
// ----------------------------------------------------------------------------
module rrp_parser
   import rrp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step_en,
   input  logic [7:0] data_byte,
   input  logic       new_connection,
   input  cfg_type    cfg,
   output result_type res
);

   phase_type         phase_ff, phase_in, c_phase;
   logic [ACC_W-1:0]  acc_ff, acc_in, c_acc;
   logic [LINE_W-1:0] line_ff, line_in, c_line;
   logic [7:0]        exp_ff, exp_in, c_exp;
   logic [7:0]        args_ff, args_in, c_args;
   logic [ACC_W-1:0]  rem_ff, rem_in, c_rem;
   logic              err_ff, err_in, c_err;

   logic              is_cnt;
   logic              lf_phase;
   logic [LINE_W-1:0] lim;
   logic [LINE_W:0]   lb;
   logic              is_digit;
   logic [ACC_W+3:0]  acc_wide;
   logic [ACC_W-1:0]  acc_next;
   logic [3:0]        line_code;
   logic [3:0]        code;
   logic [7:0]        args_inc;

   // a new connection clears all parse state ahead of this byte
   assign c_phase = new_connection ? PH_STAR : phase_ff;
   assign c_acc   = new_connection ? '0 : acc_ff;
   assign c_line  = new_connection ? '0 : line_ff;
   assign c_exp   = new_connection ? '0 : exp_ff;
   assign c_args  = new_connection ? '0 : args_ff;
   assign c_rem   = new_connection ? '0 : rem_ff;
   assign c_err   = new_connection ? 1'b0 : err_ff;

   assign is_cnt   = (c_phase == PH_CNT) || (c_phase == PH_CNT_LF);
   assign lf_phase = (c_phase == PH_CNT_LF) || (c_phase == PH_LEN_LF);
   assign lim      = is_cnt ? cfg.count_line_limit : cfg.length_line_limit;
   assign lb       = {1'b0, c_line} + (LINE_W+1)'(1);
   assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
   assign args_inc = c_args + 8'd1;

   // acc * 10 + digit, saturating
   assign acc_wide = {1'b0, c_acc, 3'b000} + {3'b000, c_acc, 1'b0}
                   + {{(ACC_W){1'b0}}, 4'(data_byte - CH_ZERO)};
   assign acc_next = (acc_wide[ACC_W+3:ACC_W] != '0) ? ACC_MAX : acc_wide[ACC_W-1:0];

   always_comb begin
      if (lb > {1'b0, lim}) begin
         line_code = ERR_LONG;
      end else if (lf_phase) begin
         if (data_byte != CH_LF) begin
            line_code = ERR_CR_NO_LF;
         end else if (lb == (LINE_W+1)'(2)) begin
            line_code = ERR_EMPTY;
         end else begin
            line_code = ERR_NONE;
         end
      end else if (is_digit || data_byte == CH_CR) begin
         line_code = ERR_NONE;
      end else begin
         line_code = ERR_DIGIT;
      end
   end

   always_comb begin
      phase_in = c_phase;
      acc_in   = c_acc;
      line_in  = c_line;
      exp_in   = c_exp;
      args_in  = c_args;
      rem_in   = c_rem;
      err_in   = c_err;
      code     = ERR_NONE;
      res.event_res  = EV_HEADER;
      res.arg_byte   = '0;
      res.arg_index  = c_args[6:0];
      res.arg_length = '0;
      res.error_code = ERR_NONE;

      if (!c_err) begin
         case (c_phase)
            PH_STAR: begin
               if (data_byte == CH_STAR) begin
                  exp_in        = '0;
                  args_in       = '0;
                  res.arg_index = '0;
                  line_in       = '0;
                  acc_in        = '0;
                  phase_in      = PH_CNT;
               end else begin
                  code = ERR_LEAD;
               end
            end
            PH_DOLLAR: begin
               if (data_byte == CH_DOLLAR) begin
                  line_in  = '0;
                  acc_in   = '0;
                  phase_in = PH_LEN;
               end else begin
                  code = ERR_LEAD;
               end
            end
            PH_CNT, PH_LEN: begin
               code = line_code;
               if (line_code == ERR_NONE) begin
                  line_in = lb[LINE_W-1:0];
                  if (is_digit) begin
                     acc_in = acc_next;
                  end else begin
                     phase_in = is_cnt ? PH_CNT_LF : PH_LEN_LF;
                  end
               end
            end
            PH_CNT_LF: begin
               code = line_code;
               if (line_code == ERR_NONE) begin
                  line_in = lb[LINE_W-1:0];
                  if (c_acc == '0 || c_acc > {{(ACC_W-8){1'b0}}, cfg.max_args} ||
                      c_acc > ARGS_BOUND_V) begin
                     code = ERR_COUNT;
                  end else begin
                     exp_in   = c_acc[7:0];
                     args_in  = '0;
                     acc_in   = '0;
                     phase_in = PH_DOLLAR;
                  end
               end
            end
            PH_LEN_LF: begin
               code = line_code;
               if (line_code == ERR_NONE) begin
                  line_in = lb[LINE_W-1:0];
                  if (c_acc > {{(ACC_W-16){1'b0}}, cfg.max_arg_len} ||
                      c_acc > LEN_BOUND_V) begin
                     code = ERR_LENGTH;
                  end else begin
                     rem_in   = c_acc;
                     phase_in = PH_DATA;
                  end
               end
            end
            PH_DATA: begin
               res.arg_length = c_acc[15:0];
               if (c_rem != '0) begin
                  res.event_res = EV_DATA;
                  res.arg_byte  = data_byte;
                  rem_in        = c_rem - ACC_W'(1);
               end else if (data_byte == CH_CR) begin
                  phase_in = PH_DATA_LF;
               end else begin
                  code = ERR_FRAME;
               end
            end
            PH_DATA_LF: begin
               res.arg_length = c_acc[15:0];
               if (data_byte == CH_LF) begin
                  args_in = args_inc;
                  if (args_inc == c_exp) begin
                     res.event_res = EV_CMD_END;
                     phase_in      = PH_STAR;
                  end else begin
                     res.event_res = EV_ARG_END;
                     phase_in      = PH_DOLLAR;
                  end
               end else begin
                  code = ERR_FRAME;
               end
            end
            default: begin
               phase_in = PH_STAR;
            end
         endcase
         if (code != ERR_NONE) begin
            err_in = 1'b1;
            acc_in = {{(ACC_W-4){1'b0}}, code};
         end
      end

      // latched error: the accumulator holds the code
      if (err_in) begin
         res.event_res  = EV_ERROR;
         res.arg_byte   = '0;
         res.arg_length = '0;
         res.error_code = acc_in[3:0];
      end
      res.arg_total = exp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_STAR;
         acc_ff   <= '0;
         line_ff  <= '0;
         exp_ff   <= '0;
         args_ff  <= '0;
         rem_ff   <= '0;
         err_ff   <= 1'b0;
      end else if (step_en) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         line_ff  <= line_in;
         exp_ff   <= exp_in;
         args_ff  <= args_in;
         rem_ff   <= rem_in;
         err_ff   <= err_in;
      end
   end

`ifndef ASSERT_OFF
   a_err_sticky: assert property (@(posedge clock) disable iff (reset)
      (err_ff && !(step_en && new_connection)) |=> err_ff)
      else $error("error cleared without a new connection");

   a_rem_in_data: assert property (@(posedge clock) disable iff (reset)
      (rem_ff != '0) |-> (phase_ff == PH_DATA))
      else $error("data bytes pending outside the data phase");

   a_args_le_exp: assert property (@(posedge clock) disable iff (reset)
      args_ff <= exp_ff)
      else $error("more arguments received than announced");
`endif

endmodule

// ----- hw/rtl/resp_request_parser_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_request_parser_top
// Streaming multi-bulk request parser: one stream byte in, one event out.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_ready   data_byte, new_connection
//   rsp_     out        rsp_valid/rsp_ready   event, byte, index, length,
//                                             total, error code
//   csr_     in         csr_write_en          csr_index, csr_wdata
//
// Event valid once the byte has passed the input register and then the parse
// step into the result register. One byte per cycle while rsp_ready is high.
// Synchronous reset restores the register defaults and the idle parse state.
// A stalled result holds the parse step; the input register keeps taking a
// byte while it is empty or the result register is free or being drained.
// ----------------------------------------------------------------------------
module resp_request_parser_top
   import rrp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_new_connection,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_event_res,
   output logic [7:0]  rsp_arg_byte,
   output logic [6:0]  rsp_arg_index,
   output logic [15:0] rsp_arg_length,
   output logic [7:0]  rsp_arg_total,
   output logic [3:0]  rsp_error_code,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type    cfg;
   result_type res;
   result_type res_ff;

   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff;
   logic       in_nc_ff;
   logic       rsp_vld_ff, rsp_vld_in;
   logic       advance;
   logic       step_en;
   logic       req_beat;

   assign advance   = !rsp_vld_ff || rsp_ready;
   assign step_en   = in_vld_ff && advance;
   assign req_ready = !in_vld_ff || advance;
   assign req_beat  = req_valid && req_ready;

   assign in_vld_in  = req_beat ? 1'b1 : (step_en ? 1'b0 : in_vld_ff);
   assign rsp_vld_in = step_en ? 1'b1 : (rsp_vld_ff && !rsp_ready);

   rrp_csr_regs u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   rrp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step_en        (step_en),
      .data_byte      (in_byte_ff),
      .new_connection (in_nc_ff),
      .cfg            (cfg),
      .res            (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_data_byte;
         in_nc_ff   <= req_new_connection;
      end
      if (step_en) begin
         res_ff <= res;
      end
   end

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_event_res  = res_ff.event_res;
   assign rsp_arg_byte   = res_ff.arg_byte;
   assign rsp_arg_index  = res_ff.arg_index;
   assign rsp_arg_length = res_ff.arg_length;
   assign rsp_arg_total  = res_ff.arg_total;
   assign rsp_error_code = res_ff.error_code;

`ifndef ASSERT_OFF
   a_err_code_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_event_res == EV_ERROR) == (rsp_error_code != ERR_NONE)))
      else $error("error code does not match event");
`endif

endmodule
